// ===== rtl/qtgr_pkg.sv =====
package qtgr_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int SIDE_W      = 8;
  localparam int GRID_SIDE_W = 9;
  localparam int SYM_W       = 3;
  localparam int ADDR_W      = 2 * SIDE_W;
  localparam int GRID_DEPTH  = MAX_SIDE * MAX_SIDE;

  localparam logic [1:0] OP_TURN  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [SYM_W-1:0] SYM_EMPTY = 3'd0;
  localparam logic [SYM_W-1:0] SYM_LEFT  = 3'd1;
  localparam logic [SYM_W-1:0] SYM_RIGHT = 3'd2;
  localparam logic [SYM_W-1:0] SYM_UP    = 3'd3;
  localparam logic [SYM_W-1:0] SYM_DOWN  = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take_item;
    logic load_result;
  } qtgr_cmd_t;

  typedef struct packed {
    logic op_read;
    logic out_full;
  } qtgr_sts_t;

  function automatic logic [SYM_W-1:0] cw_quarter(input logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] res;
    unique case (sym)
      SYM_LEFT:  res = SYM_UP;
      SYM_UP:    res = SYM_RIGHT;
      SYM_RIGHT: res = SYM_DOWN;
      SYM_DOWN:  res = SYM_LEFT;
      default:   res = SYM_EMPTY;
    endcase
    return res;
  endfunction

  function automatic logic [SYM_W-1:0] spin_symbol(input logic [SYM_W-1:0] sym,
                                                   input logic [1:0] turns);
    logic [SYM_W-1:0] s;
    s = (sym > SYM_DOWN) ? SYM_EMPTY : sym;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < turns) begin
        s = cw_quarter(s);
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/qtgr_ram.sv =====
module qtgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/qtgr_ctrl.sv =====
module qtgr_ctrl import qtgr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  input  qtgr_sts_t sts,
  output qtgr_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd.take_item   = 1'b0;
    cmd.load_result = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
        if (in_valid && sts.op_read) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_full || out_ready) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!sts.out_full || out_ready))
    else $error("result register overwritten");

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_item && sts.op_read) |=> !in_ready)
    else $error("transaction taken while read in flight");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !sts.out_full) |-> cmd.load_result)
    else $error("read result stalled with free output");

endmodule

// ===== rtl/qtgr_datapath.sv =====
module qtgr_datapath import qtgr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  qtgr_cmd_t              cmd,
  output qtgr_sts_t              sts,
  input  logic [1:0]             operation,
  input  logic                   turn_left,
  input  logic [SIDE_W-1:0]      row,
  input  logic [SIDE_W-1:0]      column,
  input  logic [SYM_W-1:0]       symbol,
  input  logic                   cfg_we,
  input  logic [GRID_SIDE_W-1:0] cfg_wdata,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SYM_W-1:0]       rotated_symbol
);

  logic [GRID_SIDE_W-1:0] grid_side;
  logic [1:0]             turns;
  logic                   in_range_q;
  logic [GRID_SIDE_W-1:0] side_n;
  logic [SIDE_W-1:0]      side_m1;
  logic                   in_range;
  logic [SIDE_W-1:0]      src_row;
  logic [SIDE_W-1:0]      src_col;
  logic                   ram_we;
  logic                   ram_re;
  logic [SYM_W-1:0]       ram_rdata;

  always_comb begin
    if (grid_side == '0) begin
      side_n = GRID_SIDE_W'(1);
    end else if (grid_side > GRID_SIDE_W'(MAX_SIDE)) begin
      side_n = GRID_SIDE_W'(MAX_SIDE);
    end else begin
      side_n = grid_side;
    end
  end

  assign side_m1  = SIDE_W'(side_n - GRID_SIDE_W'(1));
  assign in_range = ({1'b0, row} < side_n) && ({1'b0, column} < side_n);

  always_comb begin
    case (turns)
      2'd0: begin
        src_row = row;
        src_col = column;
      end
      2'd1: begin
        src_row = side_m1 - column;
        src_col = row;
      end
      2'd2: begin
        src_row = side_m1 - row;
        src_col = side_m1 - column;
      end
      default: begin
        src_row = column;
        src_col = side_m1 - row;
      end
    endcase
  end

  assign ram_we = cmd.take_item && (operation == OP_WRITE) && in_range;
  assign ram_re = cmd.take_item && (operation == OP_READ);

  qtgr_ram #(
    .WIDTH (SYM_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({row, column}),
    .wdata (symbol),
    .re    (ram_re),
    .raddr ({src_row, src_col}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= GRID_SIDE_W'(1);
      turns     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        grid_side <= cfg_wdata;
      end
      if (cmd.take_item && (operation == OP_TURN)) begin
        turns <= turn_left ? turns - 2'd1 : turns + 2'd1;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      in_range_q <= in_range;
    end
    if (cmd.load_result) begin
      rotated_symbol <= in_range_q ? spin_symbol(ram_rdata, turns) : SYM_EMPTY;
    end
  end

  assign sts.op_read  = (operation == OP_READ);
  assign sts.out_full = out_valid;

  a_rise_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_result))
    else $error("result appeared without load");

  a_symbol_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rotated_symbol <= SYM_DOWN))
    else $error("illegal rotated symbol");

  a_write_in_grid: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (row <= side_m1 && column <= side_m1))
    else $error("write outside grid");

endmodule

// ===== rtl/quarter_turn_grid_rotator.sv =====
// Channel   Handshake            Payload
// input     in_valid/in_ready    operation, turn_left, row, column, symbol
// output    out_valid/out_ready  rotated_symbol
// config    cfg_we               cfg_wdata (grid side)
//
// Turn and write transactions leave the controller idle; a read goes through the
// registered read port of the grid memory and waits in the finish state.
// A read result waits in the output register; the next transaction is taken
// while it waits, and a second read stalls only until the first is taken.
// Synchronous reset clears turns and output valid and sets the grid side to one; the grid
// memory is not cleared and no clearing pass runs.
module quarter_turn_grid_rotator import qtgr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             operation,
  input  logic                   turn_left,
  input  logic [SIDE_W-1:0]      row,
  input  logic [SIDE_W-1:0]      column,
  input  logic [SYM_W-1:0]       symbol,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SYM_W-1:0]       rotated_symbol,
  input  logic                   cfg_we,
  input  logic [GRID_SIDE_W-1:0] cfg_wdata
);

  qtgr_cmd_t cmd;
  qtgr_sts_t sts;

  qtgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qtgr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (operation),
    .turn_left      (turn_left),
    .row            (row),
    .column         (column),
    .symbol         (symbol),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rotated_symbol (rotated_symbol)
  );

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qtgr_pkg::*;

  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int         IDLE_LIMIT = 2000;
  localparam int         LONG_HOLD  = 300;
  localparam int         SETTLE     = 4;
  localparam int         PHASE_LEN  = 85;

  typedef enum logic {ROW_ITEM, ROW_SIDE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [1:0]             op;
    logic                   turn_l;
    logic [SIDE_W-1:0]      r;
    logic [SIDE_W-1:0]      c;
    logic [SYM_W-1:0]       sym;
    logic [GRID_SIDE_W-1:0] side;
    logic                   pinned;
    logic [SYM_W-1:0]       want;
  } script_row_t;

  typedef struct {
    logic [SYM_W-1:0] sym;
    int               item;
  } rotated_want_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             operation;
  logic                   turn_left;
  logic [SIDE_W-1:0]      row;
  logic [SIDE_W-1:0]      column;
  logic [SYM_W-1:0]       symbol;
  logic                   out_valid;
  logic                   out_ready;
  logic [SYM_W-1:0]       rotated_symbol;
  logic                   cfg_we;
  logic [GRID_SIDE_W-1:0] cfg_wdata;

  logic                   pin_now;
  logic [SYM_W-1:0]       pin_sym;

  // predictor state
  logic [GRID_SIDE_W-1:0] side_cfg = 9'd1;
  logic [1:0]             turns_cw = 2'd0;
  logic [SYM_W-1:0]       grid_copy [GRID_DEPTH];
  logic [SYM_W-1:0]       cw_next [5] = '{SYM_EMPTY, SYM_UP, SYM_DOWN, SYM_RIGHT, SYM_LEFT};
  rotated_want_t          pending_symbols [$];

  // stimulus bookkeeping
  bit written_cells [GRID_DEPTH];
  int filled_addrs [$];
  int offered       = 0;
  int burst_left    = 0;
  int gap_max       = 3;

  int items_taken     = 0;
  int symbols_checked = 0;
  int mismatches      = 0;
  int sides_used      = 0;
  int hold_asked      = 0;
  int hold_served     = 0;
  int hold_left       = 0;
  int rx_cycle        = 0;
  int idle_cycles     = 0;
  rotated_want_t      got_want;

  int side_plan [12] = '{2, 3, 1, 5, 8, 256, 16, 511, 0, 4, 7, 130};

  script_row_t script [26] = '{
    '{ROW_ITEM, OP_WRITE, 1'b0, 8'd0,   8'd0,   SYM_UP,    9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b1, SYM_UP},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd255, 8'd255, SYM_EMPTY, 9'd0,   1'b1, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd0,   8'd1,   SYM_EMPTY, 9'd0,   1'b1, SYM_EMPTY},
    '{ROW_ITEM, OP_TURN,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_TURN,  1'b1, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_TURN,  1'b1, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_SPARE, 1'b1, 8'd255, 8'd255, 3'd7,      9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_WRITE, 1'b0, 8'd1,   8'd0,   SYM_DOWN,  9'd0,   1'b0, SYM_EMPTY},
    '{ROW_SIDE, OP_TURN,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd256, 1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_WRITE, 1'b0, 8'd255, 8'd255, 3'd7,      9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_WRITE, 1'b0, 8'd0,   8'd0,   SYM_LEFT,  9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_WRITE, 1'b0, 8'd0,   8'd255, SYM_RIGHT, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_WRITE, 1'b0, 8'd255, 8'd0,   SYM_DOWN,  9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd255, 8'd255, SYM_EMPTY, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_TURN,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd255, 8'd255, SYM_EMPTY, 9'd0,   1'b1, SYM_EMPTY},
    '{ROW_SIDE, OP_TURN,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd0,   1'b1, SYM_LEFT},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd0,   8'd1,   SYM_EMPTY, 9'd0,   1'b1, SYM_EMPTY},
    '{ROW_SIDE, OP_TURN,  1'b0, 8'd0,   8'd0,   SYM_EMPTY, 9'd511, 1'b0, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd255, 8'd255, SYM_EMPTY, 9'd0,   1'b1, SYM_EMPTY},
    '{ROW_ITEM, OP_READ,  1'b0, 8'd0,   8'd255, SYM_EMPTY, 9'd0,   1'b1, SYM_RIGHT}
  };

  quarter_turn_grid_rotator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .turn_left      (turn_left),
    .row            (row),
    .column         (column),
    .symbol         (symbol),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rotated_symbol (rotated_symbol),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int side_in_force();
    if (side_cfg == 0) return 1;
    if (side_cfg > MAX_SIDE) return MAX_SIDE;
    return int'(side_cfg);
  endfunction

  function automatic logic [SYM_W-1:0] rotated_lookup(logic [SIDE_W-1:0] r,
                                                      logic [SIDE_W-1:0] c);
    int n;
    int sr;
    int sc;
    logic [SYM_W-1:0] s;
    n = side_in_force();
    if (r >= n || c >= n) return SYM_EMPTY;
    case (turns_cw)
      2'd0: begin sr = r;         sc = c;         end
      2'd1: begin sr = n - 1 - c; sc = r;         end
      2'd2: begin sr = n - 1 - r; sc = n - 1 - c; end
      default: begin sr = c;      sc = n - 1 - r; end
    endcase
    s = grid_copy[sr * MAX_SIDE + sc];
    if (s > SYM_DOWN) return SYM_EMPTY;
    repeat (turns_cw) s = cw_next[s];
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(0, 99) < 12) return SYM_W'($urandom_range(5, 7));
    return SYM_W'($urandom_range(0, 4));
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // track the predictor alongside every accepted input transaction
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      items_taken++;
      case (operation)
        OP_TURN:  turns_cw = turns_cw + (turn_left ? 2'd3 : 2'd1);
        OP_WRITE: if (row < side_in_force() && column < side_in_force())
                    grid_copy[{row, column}] = symbol;
        OP_READ:  pending_symbols.push_back('{pin_now ? pin_sym : rotated_lookup(row, column),
                                              items_taken});
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_symbols.size() == 0) begin
        flag_mismatch($sformatf("rotated_symbol %0d with no read outstanding", rotated_symbol));
      end else begin
        got_want = pending_symbols.pop_front();
        if (rotated_symbol !== got_want.sym)
          flag_mismatch($sformatf("read #%0d rotated_symbol %0d, want %0d",
                                  got_want.item, rotated_symbol, got_want.sym));
        else
          symbols_checked++;
      end
    end
  end

  // receiver: long hold on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 400) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 9) < 3);
        default: out_ready <= (rx_cycle % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(logic [1:0] op, logic tl, logic [SIDE_W-1:0] r,
                           logic [SIDE_W-1:0] c, logic [SYM_W-1:0] sym,
                           logic pin, logic [SYM_W-1:0] want);
    int gap;
    int addr;
    addr = r * MAX_SIDE + c;
    if (op == OP_WRITE && r < side_in_force() && c < side_in_force() && !written_cells[addr]) begin
      written_cells[addr] = 1'b1;
      filled_addrs.push_back(addr);
    end
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    offered++;
    in_valid  <= 1'b1;
    operation <= op;
    turn_left <= tl;
    row       <= r;
    column    <= c;
    symbol    <= sym;
    pin_now   <= pin;
    pin_sym   <= want;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic wait_quiet();
    @(posedge clk);
    while (pending_symbols.size() != 0) @(posedge clk);
  endtask

  task automatic set_side(logic [GRID_SIDE_W-1:0] v);
    in_valid <= 1'b0;
    wait_quiet();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    side_cfg = v;
    sides_used++;
  endtask

  // write every not yet written cell whose content a read of (r, c) may land on, at any turn count
  task automatic fill_orbit(int r, int c);
    int n;
    int rr [4];
    int cc [4];
    n = side_in_force();
    if (r >= n || c >= n) return;
    rr = '{r, n - 1 - c, n - 1 - r, c};
    cc = '{c, r, n - 1 - c, n - 1 - r};
    for (int k = 0; k < 4; k++)
      if (!written_cells[rr[k] * MAX_SIDE + cc[k]])
        push_item(OP_WRITE, 1'b0, SIDE_W'(rr[k]), SIDE_W'(cc[k]), pick_symbol(),
                  1'b0, SYM_EMPTY);
  endtask

  task automatic random_item();
    int pick;
    int n;
    int r;
    int c;
    int a;
    pick = $urandom_range(0, 99);
    n = side_in_force();
    r = $urandom_range(0, n - 1);
    c = $urandom_range(0, n - 1);
    if (pick < 12) begin
      push_item(OP_TURN, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b0, SYM_EMPTY);
    end else if (pick < 42) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 255);
        c = $urandom_range(0, 255);
      end
      push_item(OP_WRITE, 1'($urandom_range(0, 1)), SIDE_W'(r), SIDE_W'(c), pick_symbol(),
                1'b0, SYM_EMPTY);
    end else if (pick < 94) begin
      a = $urandom_range(0, 9);
      if (a < 6 && filled_addrs.size() > 0) begin
        a = filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
        if (a / MAX_SIDE < n && a % MAX_SIDE < n) begin
          r = a / MAX_SIDE;
          c = a % MAX_SIDE;
        end
      end else if (a >= 8) begin
        r = $urandom_range(0, 255);
        c = $urandom_range(0, 255);
      end
      fill_orbit(r, c);
      push_item(OP_READ, 1'($urandom_range(0, 1)), SIDE_W'(r), SIDE_W'(c),
                3'($urandom_range(0, 7)), 1'b0, SYM_EMPTY);
    end else begin
      push_item(OP_SPARE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b0, SYM_EMPTY);
    end
  endtask

  initial begin
    int target;
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = OP_TURN;
    turn_left = 1'b0;
    row       = '0;
    column    = '0;
    symbol    = SYM_EMPTY;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    pin_now   = 1'b0;
    pin_sym   = SYM_EMPTY;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_SIDE)
        set_side(script[i].side);
      else
        push_item(script[i].op, script[i].turn_l, script[i].r, script[i].c,
                  script[i].sym, script[i].pinned, script[i].want);
    end

    foreach (side_plan[p]) begin
      set_side(GRID_SIDE_W'(side_plan[p]));
      gap_max = (p % 3 == 1) ? 0 : $urandom_range(2, 8);
      if (side_plan[p] == MAX_SIDE) hold_asked <= hold_asked + 1;
      target = offered + PHASE_LEN;
      while (offered < target) random_item();
    end

    in_valid <= 1'b0;
    wait_quiet();
    repeat (8) @(posedge clk);
    if (pending_symbols.size() != 0)
      flag_mismatch($sformatf("%0d reads never answered", pending_symbols.size()));

    $display("Ran %0d transactions, %0d rotated symbols checked, %0d grid side settings.",
             items_taken, symbols_checked, sides_used);
    $display("Covered turns both ways, out-of-grid and spare ops, codes above four, long stall.");
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
